>>> sv/base64_decoder_assert.svh
// Assertion macros used by the base64 decoder checker.
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/b64d_pkg.sv
// Shared types, constants and the character classifier of the base64 decoder.
package b64d_pkg;

   // Largest number of bytes carried by one decode job, most significant byte first
   localparam int JOB_BYTES = 3;

   // Sextet code returned for characters outside the alphabet
   localparam logic [6:0] SEXTET_INVALID = 7'h40;

   // Special alphabet characters
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;

   // One decoded input item waiting for the result side
   typedef struct packed {
      logic [23:0] bytes;   // first byte in [23:16]
      logic [1:0]  count;   // bytes carried, 0..3
      logic        eos;     // item closed the string
   } job_type;

   // Map a character to its six-bit value; bit 6 set means not in the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = SEXTET_INVALID;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == CHAR_PLUS) begin
         v = 7'd62;
      end else if (c == CHAR_SLASH) begin
         v = 7'd63;
      end
      return v;
   endfunction

endpackage

>>> sv/b64d_ifs.sv
// Valid/ready channel interfaces for encoded characters and decoded bytes.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_string;

   modport source (output valid, output char_in, output end_of_string, input ready);
   modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       run_last;
   logic       message_end;

   modport source (output valid, output data_byte, output byte_valid,
                   output run_last, output message_end, input ready);
   modport sink   (input valid, input data_byte, input byte_valid,
                   input run_last, input message_end, output ready);
endinterface

>>> sv/b64d_front.sv
// Front end: accepts characters, tracks the group state and forms decode jobs.
module b64d_front (
   input  logic               clock,
   input  logic               reset,
   b64d_req_if.sink           req_ch,
   input  logic               q_full,
   output logic               push,
   output b64d_pkg::job_type  push_job
);

   logic [1:0]  count_ff, count_in;
   logic [17:0] store_ff, store_in;
   logic        stopped_ff, stopped_in;

   logic        accept;
   logic [6:0]  sx;
   logic        is_val, grow, full, do_flush;
   logic [1:0]  k_new, fk;
   logic [17:0] s_new, fs;
   logic [23:0] bytes;
   logic [1:0]  nbytes;
   logic        eos;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign eos          = req_ch.end_of_string;

   // Classify the character and work out the group after it
   always_comb begin
      sx       = b64d_pkg::sextet_of(req_ch.char_in);
      is_val   = !sx[6];
      grow     = !stopped_ff && is_val;
      full     = grow && (count_ff == 2'd3);
      k_new    = count_ff + 2'd1;
      s_new    = {store_ff[11:0], sx[5:0]};
      do_flush = !stopped_ff && (!is_val || eos);
      fk       = is_val ? (full ? 2'd0 : k_new) : count_ff;
      fs       = is_val ? s_new : store_ff;
   end

   // Form the bytes of a full group or of a flushed partial group
   always_comb begin
      bytes  = '0;
      nbytes = 2'd0;
      priority if (full) begin
         bytes  = {store_ff, sx[5:0]};
         nbytes = 2'd3;
      end else if (do_flush && fk == 2'd2) begin
         bytes  = {fs[11:4], 16'h0000};
         nbytes = 2'd1;
      end else if (do_flush && fk == 2'd3) begin
         bytes  = {fs[17:10], fs[9:2], 8'h00};
         nbytes = 2'd2;
      end else begin
         // No byte from this character
         bytes  = '0;
         nbytes = 2'd0;
      end
   end

   // Queue a job when it carries bytes or closes the string
   assign push           = accept && (nbytes != 2'd0 || eos);
   assign push_job.bytes = bytes;
   assign push_job.count = nbytes;
   assign push_job.eos   = eos;

   // Advance the group state
   always_comb begin
      count_in   = count_ff;
      store_in   = store_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         priority if (eos) begin
            count_in   = 2'd0;
            store_in   = '0;
            stopped_in = 1'b0;
         end else if (full) begin
            count_in = 2'd0;
            store_in = '0;
         end else if (grow) begin
            count_in = k_new;
            store_in = s_new;
         end else if (!stopped_ff) begin
            count_in   = 2'd0;
            store_in   = '0;
            stopped_in = 1'b1;
         end else begin
            // Ignore characters after a stop
            count_in   = count_ff;
            store_in   = store_ff;
            stopped_in = stopped_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 2'd0;
         store_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         store_ff   <= store_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

>>> sv/b64d_queue.sv
// Short job queue between the front end and the result side.
module b64d_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64d_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output b64d_pkg::job_type  head_job,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64d_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      fill_in = fill_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Write the job into its slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> sv/b64d_back.sv
// Result side: unpacks queued jobs into one registered result per cycle while a job waits and the receiver is ready.
module b64d_back (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::job_type  head_job,
   input  logic               empty,
   output logic               pop,
   b64d_rsp_if.source         rsp_ch
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       last_ff, last_in;
   logic       mend_ff, mend_in;

   logic       load;
   logic [1:0] nres;
   logic       is_last;

   assign load    = !empty && (!valid_ff || rsp_ch.ready);
   assign nres    = (head_job.count == 2'd0) ? 2'd1 : head_job.count;
   assign is_last = (idx_ff == nres - 2'd1);
   assign pop     = load && is_last;

   // Pick the next byte of the head job
   always_comb begin
      unique case (idx_ff)
         2'd0:    byte_in = head_job.bytes[23:16];
         2'd1:    byte_in = head_job.bytes[15:8];
         default: byte_in = head_job.bytes[7:0];
      endcase
      bvalid_in = (head_job.count != 2'd0);
      last_in   = is_last;
      mend_in   = is_last && head_job.eos;
   end

   // Step through the job and hold the output while stalled
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         mend_ff   <= mend_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.data_byte   = byte_ff;
   assign rsp_ch.byte_valid  = bvalid_ff;
   assign rsp_ch.run_last    = last_ff;
   assign rsp_ch.message_end = mend_ff;

endmodule

>>> sv/base64_decoder.sv
// Top level of the streaming base64 decoder.
//
//   channel  dir  payload                                        handshake
//   req_ch   in   char_in[8], end_of_string                      valid/ready
//   rsp_ch   out  data_byte[8], byte_valid, run_last, message_end valid/ready
//
// Takes one character per cycle; ready drops only when the job queue is full.
// Gives one result per cycle while rsp_ch is ready; a full group gives three results.
// An accepted item is written into the job queue, then loaded into the registered result.
// QUEUE_DEPTH jobs of up to three bytes absorb output stalls and bursts.
// Reset is synchronous and clears group state, queue pointers and output valid.
module base64_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_ch,
   b64d_rsp_if.source  rsp_ch
);

   logic              q_push, q_full, q_pop, q_empty;
   b64d_pkg::job_type q_in_job, q_head_job;

   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push     (q_push),
      .push_job (q_in_job)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (q_head_job),
      .empty    (q_empty)
   );

   b64d_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (q_head_job),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> sv/b64d_checker.sv
// Port-level checker for the base64 decoder and its bind.
`include "base64_decoder_assert.svh"

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_message_end
);

   // A stalled result holds
   `B64D_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_message_end), "stalled result changed")

   // An empty result closes both the item and the string
   `B64D_ASSERT_NOW(a_empty_closes, rsp_valid && !rsp_byte_valid, rsp_run_last && rsp_message_end, "empty result not final")

   // An empty result carries a zero byte
   `B64D_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp_byte_valid, rsp_data_byte == 8'h00, "empty result with nonzero byte")

   // The end of a string is always the last result of its item
   `B64D_ASSERT_NOW(a_end_last, rsp_valid && rsp_message_end, rsp_run_last, "string end without item end")

endmodule

bind base64_decoder b64d_checker u_b64d_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_data_byte   (rsp_ch.data_byte),
   .rsp_byte_valid  (rsp_ch.byte_valid),
   .rsp_run_last    (rsp_ch.run_last),
   .rsp_message_end (rsp_ch.message_end)
);

>>> bench/tb_top.sv
// Self-checking bench for the base64 decoder: random bursts in, stalled results out.
`timescale 1ns / 100ps

module tb_top;

   localparam logic [7:0] CHAR_PAD   = 8'h3d;
   localparam int         IDLE_LIMIT = 2000;
   localparam int         RAND_ITEMS = 92;
   localparam int         TAIL_WAIT  = 8;

   // One encoded character as offered on the request channel
   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_string;
   } char_item_type;

   // One decoded result as seen on the response channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       run_last;
      logic       message_end;
   } byte_result_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HALF} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64d_req_if req_bus ();
   b64d_rsp_if rsp_bus ();

   base64_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   char_item_type   pending_q[$];
   byte_result_type decoded_q[$];
   int              mismatch_count = 0;
   logic            req_fire = 1'b0;

   // Character to sextet table, built from the alphabet at start
   logic [6:0]   value_lut [256];

   // Decoder state of the prediction
   logic [1:0]   grp_cnt = 2'd0;
   logic [17:0]  sextets = 18'd0;
   logic         halted = 1'b0;
   logic [7:0]   out_bytes [b64d_pkg::JOB_BYTES];
   int           out_n;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Map an index 0..63 to its alphabet character
   function automatic logic [7:0] alpha_char(input int unsigned idx);
      if (idx < 26) begin
         return 8'(8'h41 + idx);
      end else if (idx < 52) begin
         return 8'(8'h61 + idx - 26);
      end else if (idx < 62) begin
         return 8'(8'h30 + idx - 52);
      end else if (idx == 62) begin
         return b64d_pkg::CHAR_PLUS;
      end
      return b64d_pkg::CHAR_SLASH;
   endfunction

   // Emit k-1 bytes of a partial group of k sextets, then empty the group
   task flush_group;
      logic [23:0] w;
      w = {6'd0, sextets} << (6 * (4 - grp_cnt));
      if (grp_cnt >= 2) begin
         out_bytes[out_n] = w[23:16];
         out_n++;
         if (grp_cnt == 3) begin
            out_bytes[out_n] = w[15:8];
            out_n++;
         end
      end
      grp_cnt = 2'd0;
      sextets = 18'd0;
   endtask

   // Advance the predicted decoder by one character and queue its results
   task decode_char(input logic [7:0] ch, input logic eos);
      logic [6:0]      v;
      logic [23:0]     w;
      byte_result_type r;
      int              i;
      out_n = 0;
      if (!halted) begin
         v = value_lut[ch];
         if (!v[6]) begin
            if (grp_cnt == 2'd3) begin
               w = {sextets, v[5:0]};
               out_bytes[0] = w[23:16];
               out_bytes[1] = w[15:8];
               out_bytes[2] = w[7:0];
               out_n = 3;
               grp_cnt = 2'd0;
               sextets = 18'd0;
            end else begin
               sextets = {sextets[11:0], v[5:0]};
               grp_cnt = grp_cnt + 2'd1;
            end
            if (eos) flush_group();
         end else begin
            flush_group();
            halted = 1'b1;
         end
      end
      if (eos) begin
         grp_cnt = 2'd0;
         sextets = 18'd0;
         halted = 1'b0;
         if (out_n == 0) begin
            r = '{data_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                  message_end: 1'b1};
            decoded_q.insert(decoded_q.size(), r);
         end
      end
      for (i = 0; i < out_n; i++) begin
         r.data_byte   = out_bytes[i];
         r.byte_valid  = 1'b1;
         r.run_last    = (i == out_n - 1);
         r.message_end = (i == out_n - 1) && eos;
         decoded_q.insert(decoded_q.size(), r);
      end
   endtask

   // Queue one character for the driver
   task add_char(input logic [7:0] ch, input logic eos);
      char_item_type it;
      it.char_in = ch;
      it.end_of_string = eos;
      pending_q.insert(pending_q.size(), it);
   endtask

   // Queue a text, the end flag on its last character when asked
   task add_text(input string s, input logic eos_last);
      int i;
      for (i = 0; i < s.len(); i++) begin
         add_char(s[i], eos_last && (i == s.len() - 1));
      end
   endtask

   // Drive characters in bursts with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin : driver
      char_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            nxt = pending_q.pop_front();
            req_bus.char_in <= nxt.char_in;
            req_bus.end_of_string <= nxt.end_of_string;
            req_bus.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Stall the result side on a changing pattern
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   logic [7:0]  rx_tick = 8'd0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= 49;
      end else begin
         rx_left <= rx_left - 1;
      end
      unique case (rx_mode)
         RX_OPEN: begin
            rsp_bus.ready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_bus.ready <= ($urandom_range(0, 9) < 6);
         end
         RX_SPARSE: begin
            rsp_bus.ready <= (rx_tick[1:0] == 2'd0);
         end
         default: begin
            rsp_bus.ready <= rx_tick[1];
         end
      endcase
      rx_tick <= rx_tick + 8'd1;
   end

   // Predict on accepted characters, check accepted results
   always @(posedge clock) begin : monitor
      byte_result_type got, want;
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         decode_char(req_bus.char_in, req_bus.end_of_string);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.data_byte   = rsp_bus.data_byte;
         got.byte_valid  = rsp_bus.byte_valid;
         got.run_last    = rsp_bus.run_last;
         got.message_end = rsp_bus.message_end;
         if (decoded_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: byte %02h valid %b run_last %b end %b",
                        got.data_byte, got.byte_valid, got.run_last, got.message_end);
         end else begin
            want = decoded_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want byte %02h valid %b run_last %b end %b, %s%02h %b %b %b",
                           want.data_byte, want.byte_valid, want.run_last, want.message_end,
                           "got ", got.data_byte, got.byte_valid, got.run_last,
                           got.message_end);
            end
         end
      end
   end

   // End the run when nothing moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("base64_decoder regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] word_q[$];
      logic [7:0] b;
      int         rand_count;
      int         kind, groups, tail, n, i;

      for (i = 0; i < 256; i++) value_lut[i] = b64d_pkg::SEXTET_INVALID;
      for (i = 0; i < 64; i++) value_lut[alpha_char(i)] = 7'(i);

      // Directed: extreme groups, pad stops, partial ends, invalid bytes
      add_text("AAAA", 1'b1);
      add_text("////", 1'b1);
      add_text("+9azZg==", 1'b1);
      add_text("QUI=", 1'b1);
      add_text("Zg", 1'b1);
      add_text("Q", 1'b1);
      add_char(8'hff, 1'b1);
      add_char(8'h51, 1'b0);
      add_char(8'h80, 1'b0);
      add_char(8'h00, 1'b1);

      // Random strings: mostly well formed, some broken, some noise
      rand_count = 0;
      while (rand_count < RAND_ITEMS) begin
         word_q.delete();
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            groups = $urandom_range(0, 3);
            tail = $urandom_range(0, 3);
            for (i = 0; i < 4 * groups + tail; i++)
               word_q.insert(word_q.size(), alpha_char($urandom_range(0, 63)));
            if (tail >= 2 && $urandom_range(0, 1))
               for (i = tail; i < 4; i++) word_q.insert(word_q.size(), CHAR_PAD);
            if (word_q.size() == 0)
               word_q.insert(word_q.size(), alpha_char($urandom_range(0, 63)));
         end else if (kind < 9) begin
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
               word_q.insert(word_q.size(), alpha_char($urandom_range(0, 63)));
            do begin
               b = 8'($urandom_range(0, 255));
            end while (!value_lut[b][6]);
            word_q.insert(word_q.size(), b);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
               word_q.insert(word_q.size(), 8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
               word_q.insert(word_q.size(), 8'($urandom_range(0, 255)));
         end
         for (i = 0; i < word_q.size(); i++) add_char(word_q[i], i == word_q.size() - 1);
         rand_count += word_q.size();
      end

      // Hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain stimulus, then results, then let the pipeline settle
      while (pending_q.size() != 0 || req_bus.valid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (decoded_q.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("base64_decoder regression: pass");
      end else begin
         $display("base64_decoder regression: fail");
      end
      $finish;
   end

endmodule
